// ----- sv/vwc_pkg.sv -----
// ----------------------------------------------------------------------------
// vwc_pkg
// Shared types and constants of the volume weighted centroid core: register
// map, accumulator widths, the sums snapshot and the back end state codes.
// ----------------------------------------------------------------------------
package vwc_pkg;

   // configuration registers, all 9 bits wide
   localparam int CFG_W    = 9;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;
   localparam int REG_IW   = 3;

   localparam logic [REG_IW-1:0] REG_X_SIZE      = 3'd0;
   localparam logic [REG_IW-1:0] REG_Y_SIZE      = 3'd1;
   localparam logic [REG_IW-1:0] REG_Z_SIZE      = 3'd2;
   localparam logic [REG_IW-1:0] REG_FIRST_SLICE = 3'd3;
   localparam logic [REG_IW-1:0] REG_LAST_SLICE  = 3'd4;

   localparam logic [CFG_W-1:0] SIZE_RESET  = 9'd256;
   localparam logic [CFG_W-1:0] FIRST_RESET = 9'd1;
   localparam logic [CFG_W-1:0] LAST_RESET  = 9'd256;

   // accumulator and result widths
   localparam int VOX_W  = 16;
   localparam int W_BITS = 40;
   localparam int M_BITS = 48;
   localparam int OUT_W  = 16;

   // sums queue between front and back
   localparam int QDEPTH = 2;
   localparam int QLVL_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [CFG_W-1:0] x_size;
      logic [CFG_W-1:0] y_size;
      logic [CFG_W-1:0] z_size;
      logic [CFG_W-1:0] first_slice;
      logic [CFG_W-1:0] last_slice;
   } vwc_cfg_type;

   typedef struct packed {
      logic [W_BITS-1:0] weight;
      logic [M_BITS-1:0] x_mom;
      logic [M_BITS-1:0] y_mom;
      logic [M_BITS-1:0] z_mom;
   } vwc_sums_type;

   typedef struct packed {
      logic              not_empty;
      logic [QLVL_W-1:0] level;
   } vwc_qstat_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_DIV  = 2'd1,
      BK_HOLD = 2'd2
   } vwc_state_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } vwc_axis_type;

endpackage

// ----- sv/volume_weighted_centroid_core.sv -----
// ----------------------------------------------------------------------------
// volume_weighted_centroid_core
// Intensity weighted 3-D centroid of a raster voxel stream, Q8.8 output.
// ----------------------------------------------------------------------------
// Voxels are taken one per clock in raster order (x fastest, then y, then z)
// for as long as full stays low; the core tracks the position itself and
// sums intensity and intensity times x, y and z over the slices from
// first_slice to last_slice. The sums of a finished volume enter a two-entry
// queue, so the stream runs on into the next volume while a shared restoring
// divider works out x, y and z one after another, one quotient bit per clock.
// A volume with zero weight skips the divider. full rises only while two
// finished volumes, queued or still in the front end pipeline, wait for the
// divider, which bounds the rate for very small volumes to one volume per
// divider pass. Results saturate to 0xFFFF; a zero intensity sum gives
// no_weight with zero coordinates. Configuration is to be written only while
// the core is idle; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module volume_weighted_centroid_core
   import vwc_pkg::*;
#(
   parameter int MAX_X     = 256,
   parameter int MAX_Y     = 256,
   parameter int MAX_Z     = 256,
   parameter int FRAC_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   // voxel beats
   input  logic              push,
   output logic              full,
   input  logic [VOX_W-1:0]  req_voxel,
   // centroid beats
   output logic              empty,
   input  logic              pop,
   output logic [OUT_W-1:0]  rsp_center_x,
   output logic [OUT_W-1:0]  rsp_center_y,
   output logic [OUT_W-1:0]  rsp_center_z,
   output logic              rsp_no_weight,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   vwc_cfg_type       cfg_ff, cfg_in;
   logic              csr_wr;
   logic [REG_IW-1:0] csr_idx;
   logic [CFG_W-1:0]  csr_val;

   vwc_qstat_type     qstat;
   vwc_sums_type      q_wdata, q_rdata;
   logic              q_push, q_pop;

   // register write
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[CSR_AW-1:2];
   assign csr_val = pwdata[CFG_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_X_SIZE:      cfg_in.x_size      = csr_val;
            REG_Y_SIZE:      cfg_in.y_size      = csr_val;
            REG_Z_SIZE:      cfg_in.z_size      = csr_val;
            REG_FIRST_SLICE: cfg_in.first_slice = csr_val;
            REG_LAST_SLICE:  cfg_in.last_slice  = csr_val;
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_size      <= SIZE_RESET;
         cfg_ff.y_size      <= SIZE_RESET;
         cfg_ff.z_size      <= SIZE_RESET;
         cfg_ff.first_slice <= FIRST_RESET;
         cfg_ff.last_slice  <= LAST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read
   always_comb begin
      case (csr_idx)
         REG_X_SIZE:      prdata = CSR_DW'(cfg_ff.x_size);
         REG_Y_SIZE:      prdata = CSR_DW'(cfg_ff.y_size);
         REG_Z_SIZE:      prdata = CSR_DW'(cfg_ff.z_size);
         REG_FIRST_SLICE: prdata = CSR_DW'(cfg_ff.first_slice);
         REG_LAST_SLICE:  prdata = CSR_DW'(cfg_ff.last_slice);
         default:         prdata = '0;
      endcase
   end

   // front end: counters, weighting, accumulation
   vwc_front #(
      .MAX_X (MAX_X),
      .MAX_Y (MAX_Y),
      .MAX_Z (MAX_Z)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .voxel    (req_voxel),
      .qstat    (qstat),
      .full     (full),
      .sum_push (q_push),
      .sums     (q_wdata)
   );

   // finished volume sums
   vwc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .qstat (qstat)
   );

   // divider and result register
   vwc_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .rdata     (q_rdata),
      .q_pop     (q_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .center_x  (rsp_center_x),
      .center_y  (rsp_center_y),
      .center_z  (rsp_center_z),
      .no_weight (rsp_no_weight)
   );

endmodule

// ----- sv/vwc_front.sv -----
// ----------------------------------------------------------------------------
// vwc_front
// Voxel front end: raster position counters, slice window test, weighting
// multipliers and the four accumulators. At the last voxel of a volume the
// completed sums go to the queue and the accumulators clear.
// ----------------------------------------------------------------------------
module vwc_front
   import vwc_pkg::*;
#(
   parameter int MAX_X = 256,
   parameter int MAX_Y = 256,
   parameter int MAX_Z = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  vwc_cfg_type        cfg,
   input  logic               push,
   input  logic [VOX_W-1:0]   voxel,
   input  vwc_qstat_type      qstat,
   output logic               full,
   output logic               sum_push,
   output vwc_sums_type       sums
);

   localparam int CWX = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int CWY = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int CWZ = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
   localparam int SWX = $clog2(MAX_X + 1);
   localparam int SWY = $clog2(MAX_Y + 1);
   localparam int SWZ = $clog2(MAX_Z + 1);
   localparam int PXW = VOX_W + CWX;
   localparam int PYW = VOX_W + CWY;
   localparam int PZW = VOX_W + CWZ;

   logic [SWX-1:0] xs;
   logic [SWY-1:0] ys;
   logic [SWZ-1:0] zs;

   logic [CWX-1:0] col_ff, col_in;
   logic [CWY-1:0] row_ff, row_in;
   logic [CWZ-1:0] slice_ff, slice_in;
   logic [CWX:0]   col_nx;
   logic [CWY:0]   row_nx;
   logic [CWZ:0]   slice_nx;
   logic           last_col, last_row, last_slc, last_vox, incl, accept;

   // stage A: registered beat with its position
   logic             a_valid_ff, a_valid_in;
   logic             a_last_ff, a_last_in;
   logic             a_incl_ff;
   logic [VOX_W-1:0] a_voxel_ff;
   logic [CWX-1:0]   a_col_ff;
   logic [CWY-1:0]   a_row_ff;
   logic [CWZ-1:0]   a_slice_ff;

   // stage B: weighted terms
   logic             b_valid_ff, b_valid_in;
   logic             b_last_ff, b_last_in;
   logic [VOX_W-1:0] b_w_ff, b_w_in;
   logic [PXW-1:0]   b_px_ff, b_px_in;
   logic [PYW-1:0]   b_py_ff, b_py_in;
   logic [PZW-1:0]   b_pz_ff, b_pz_in;

   // stage C: accumulators
   vwc_sums_type acc_ff, acc_in, sum_nx;

   // effective sizes: zero acts as one, clamp to the maximum
   always_comb begin
      if (cfg.x_size == '0) xs = SWX'(1);
      else if (32'(cfg.x_size) > 32'(MAX_X)) xs = SWX'(MAX_X);
      else xs = SWX'(cfg.x_size);
      if (cfg.y_size == '0) ys = SWY'(1);
      else if (32'(cfg.y_size) > 32'(MAX_Y)) ys = SWY'(MAX_Y);
      else ys = SWY'(cfg.y_size);
      if (cfg.z_size == '0) zs = SWZ'(1);
      else if (32'(cfg.z_size) > 32'(MAX_Z)) zs = SWZ'(MAX_Z);
      else zs = SWZ'(cfg.z_size);
   end

   // position classification
   assign accept   = push && !full;
   assign col_nx   = {1'b0, col_ff} + (CWX+1)'(1);
   assign row_nx   = {1'b0, row_ff} + (CWY+1)'(1);
   assign slice_nx = {1'b0, slice_ff} + (CWZ+1)'(1);
   assign last_col = 32'(col_nx) >= 32'(xs);
   assign last_row = 32'(row_nx) >= 32'(ys);
   assign last_slc = 32'(slice_nx) >= 32'(zs);
   assign last_vox = last_col && last_row && last_slc;
   // slice window, counted from one
   assign incl = (32'(slice_nx) >= 32'(cfg.first_slice)) &&
                 (32'(slice_nx) <= 32'(cfg.last_slice));

   // raster counters
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      slice_in = slice_ff;
      if (accept) begin
         if (last_vox) begin
            col_in   = '0;
            row_in   = '0;
            slice_in = '0;
         end else if (!last_col) begin
            col_in = col_nx[CWX-1:0];
         end else begin
            col_in = '0;
            if (!last_row) begin
               row_in = row_nx[CWY-1:0];
            end else begin
               row_in   = '0;
               slice_in = slice_nx[CWZ-1:0];
            end
         end
      end
   end

   // hold off while the queue could not take every volume end in flight
   assign full = (32'(qstat.level) + 32'(a_valid_ff && a_last_ff) +
                  32'(b_valid_ff && b_last_ff)) >= 32'(QDEPTH);

   // weighting terms, zero outside the slice window
   assign a_valid_in = accept;
   assign a_last_in  = last_vox;
   assign b_valid_in = a_valid_ff;
   assign b_last_in  = a_last_ff;
   assign b_w_in     = a_incl_ff ? a_voxel_ff : '0;
   assign b_px_in    = a_incl_ff ? PXW'(a_voxel_ff) * PXW'(a_col_ff) : '0;
   assign b_py_in    = a_incl_ff ? PYW'(a_voxel_ff) * PYW'(a_row_ff) : '0;
   assign b_pz_in    = a_incl_ff ? PZW'(a_voxel_ff) * PZW'(a_slice_ff) : '0;

   // accumulate; at volume end the sums leave and the accumulators clear
   always_comb begin
      sum_nx.weight = acc_ff.weight + W_BITS'(b_w_ff);
      sum_nx.x_mom  = acc_ff.x_mom + M_BITS'(b_px_ff);
      sum_nx.y_mom  = acc_ff.y_mom + M_BITS'(b_py_ff);
      sum_nx.z_mom  = acc_ff.z_mom + M_BITS'(b_pz_ff);
      acc_in        = acc_ff;
      sum_push      = 1'b0;
      if (b_valid_ff) begin
         if (b_last_ff) begin
            acc_in   = '0;
            sum_push = 1'b1;
         end else begin
            acc_in = sum_nx;
         end
      end
   end

   assign sums = sum_nx;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         slice_ff   <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         acc_ff     <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         slice_ff   <= slice_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         acc_ff     <= acc_in;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      a_last_ff  <= a_last_in;
      a_incl_ff  <= incl;
      a_voxel_ff <= voxel;
      a_col_ff   <= col_ff;
      a_row_ff   <= row_ff;
      a_slice_ff <= slice_ff;
      b_last_ff  <= b_last_in;
      b_w_ff     <= b_w_in;
      b_px_ff    <= b_px_in;
      b_py_ff    <= b_py_in;
      b_pz_ff    <= b_pz_in;
   end

   // a volume end reaching the accumulators always finds queue space
   assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_last_ff) |-> (32'(qstat.level) < 32'(QDEPTH)))
      else $error("vwc_front: volume end without queue space");

endmodule

// ----- sv/vwc_queue.sv -----
// ----------------------------------------------------------------------------
// vwc_queue
// Short queue of finished volume sums between the front end and the divider.
// ----------------------------------------------------------------------------
module vwc_queue
   import vwc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  vwc_sums_type  wdata,
   input  logic          pop,
   output vwc_sums_type  rdata,
   output vwc_qstat_type qstat
);

   localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

   vwc_sums_type      mem_ff [QDEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0] level_ff, level_in;

   // pointer and level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) level_in = level_ff + QLVL_W'(1);
      else if (pop && !push) level_in = level_ff - QLVL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wdata;
   end

   assign rdata           = mem_ff[rd_ptr_ff];
   assign qstat.not_empty = (level_ff != '0);
   assign qstat.level     = level_ff;

   assert property (@(posedge clock) disable iff (reset)
      push |-> (32'(level_ff) < 32'(QDEPTH)))
      else $error("vwc_queue: overflow");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> (level_ff != '0))
      else $error("vwc_queue: underflow");

endmodule

// ----- sv/vwc_back.sv -----
// ----------------------------------------------------------------------------
// vwc_back
// Divider back end: one shared restoring divider works out x, y and z in
// turn, one quotient bit per cycle, with saturation to 16 bits. The result
// waits in an output register until it is popped.
// ----------------------------------------------------------------------------
module vwc_back
   import vwc_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  vwc_qstat_type      qstat,
   input  vwc_sums_type       rdata,
   output logic               q_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic [OUT_W-1:0]   center_x,
   output logic [OUT_W-1:0]   center_y,
   output logic [OUT_W-1:0]   center_z,
   output logic               no_weight
);

   localparam int NB  = M_BITS + FRAC_BITS;
   localparam int SCW = $clog2(NB);

   vwc_state_type     state_ff, state_in;
   vwc_axis_type      axis_ff, axis_in;
   logic [SCW-1:0]    step_ff, step_in;
   vwc_sums_type      work_ff, work_in;
   logic [NB-1:0]     dvd_ff, dvd_in;
   logic [W_BITS-1:0] rem_ff, rem_in;
   logic [OUT_W-1:0]  quo_ff, quo_in;
   logic              sat_ff, sat_in;
   logic [OUT_W-1:0]  res_x_ff, res_x_in, res_y_ff, res_y_in, res_z_ff, res_z_in;
   logic              res_nw_ff, res_nw_in;
   logic              out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]  out_x_ff, out_x_in, out_y_ff, out_y_in, out_z_ff, out_z_in;
   logic              out_nw_ff, out_nw_in;

   logic [W_BITS:0]   rem_sh, rem_dif;
   logic              ge, last_step, out_free, rsp_take;
   logic [OUT_W-1:0]  qval;

   // one restoring step
   assign rem_sh    = {rem_ff, dvd_ff[NB-1]};
   assign ge        = rem_sh >= {1'b0, work_ff.weight};
   assign rem_dif   = rem_sh - {1'b0, work_ff.weight};
   assign qval      = (sat_ff || quo_ff[OUT_W-1]) ? '1 : {quo_ff[OUT_W-2:0], ge};
   assign last_step = (step_ff == SCW'(NB - 1));
   assign rsp_take  = rsp_pop && out_valid_ff;
   assign out_free  = !out_valid_ff || rsp_take;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (qstat.not_empty) state_in = (rdata.weight == '0) ? BK_HOLD : BK_DIV;
         end
         BK_DIV: begin
            if (last_step && axis_ff == AXIS_Z) state_in = BK_HOLD;
         end
         BK_HOLD: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop        = 1'b0;
      axis_in      = axis_ff;
      step_in      = step_ff;
      work_in      = work_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      sat_in       = sat_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_z_in     = res_z_ff;
      res_nw_in    = res_nw_ff;
      out_valid_in = out_valid_ff && !rsp_take;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_z_in     = out_z_ff;
      out_nw_in    = out_nw_ff;
      case (state_ff)
         BK_IDLE: begin
            if (qstat.not_empty) begin
               q_pop     = 1'b1;
               work_in   = rdata;
               axis_in   = AXIS_X;
               step_in   = '0;
               dvd_in    = NB'(rdata.x_mom) << FRAC_BITS;
               rem_in    = '0;
               quo_in    = '0;
               sat_in    = 1'b0;
               res_x_in  = '0;
               res_y_in  = '0;
               res_z_in  = '0;
               res_nw_in = (rdata.weight == '0);
            end
         end
         BK_DIV: begin
            rem_in  = ge ? rem_dif[W_BITS-1:0] : rem_sh[W_BITS-1:0];
            dvd_in  = dvd_ff << 1;
            quo_in  = {quo_ff[OUT_W-2:0], ge};
            sat_in  = sat_ff || quo_ff[OUT_W-1];
            step_in = step_ff + SCW'(1);
            if (last_step) begin
               step_in = '0;
               rem_in  = '0;
               quo_in  = '0;
               sat_in  = 1'b0;
               case (axis_ff)
                  AXIS_X: begin
                     res_x_in = qval;
                     axis_in  = AXIS_Y;
                     dvd_in   = NB'(work_ff.y_mom) << FRAC_BITS;
                  end
                  AXIS_Y: begin
                     res_y_in = qval;
                     axis_in  = AXIS_Z;
                     dvd_in   = NB'(work_ff.z_mom) << FRAC_BITS;
                  end
                  default: begin
                     res_z_in = qval;
                  end
               endcase
            end
         end
         BK_HOLD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_x_in     = res_x_ff;
               out_y_in     = res_y_ff;
               out_z_in     = res_z_ff;
               out_nw_in    = res_nw_ff;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         axis_ff      <= AXIS_X;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      sat_ff    <= sat_in;
      res_x_ff  <= res_x_in;
      res_y_ff  <= res_y_in;
      res_z_ff  <= res_z_in;
      res_nw_ff <= res_nw_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_z_ff  <= out_z_in;
      out_nw_ff <= out_nw_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign center_x  = out_x_ff;
   assign center_y  = out_y_ff;
   assign center_z  = out_z_ff;
   assign no_weight = out_nw_ff;

   // never divide by a zero weight
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV) |-> (work_ff.weight != '0))
      else $error("vwc_back: division by zero weight");

   // the bit counter never runs past the dividend
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV) |-> (32'(step_ff) < NB))
      else $error("vwc_back: step counter overrun");

endmodule

// ----- dv/tb_volume_weighted_centroid_core.sv -----
// ----------------------------------------------------------------------------
// tb_volume_weighted_centroid_core
// Self-checking bench for the voxel stream centroid core.
// ----------------------------------------------------------------------------
// Drives voxel beats in raster order and keeps its own model of the position
// counters, the slice window and the four accumulators. Each finished volume
// queues an expected centroid, and every popped centroid beat is checked
// against the oldest one. A short directed table covers the edge cases: one
// voxel volumes, zero weight, zero sizes, inverted and outside slice
// windows, and a size change in the middle of a volume. Random phases
// follow, each with fresh register settings, from tiny volumes up to 256
// voxels along one axis, some with clamped sizes. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_volume_weighted_centroid_core;
   import vwc_pkg::*;

   localparam int MAX_X          = 256;
   localparam int MAX_Y          = 256;
   localparam int MAX_Z          = 256;
   localparam int FRAC           = 8;
   localparam int DIVIDE_CYCLES  = 3 * (M_BITS + FRAC) + 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int N_VOXELS       = 600;

   typedef struct packed {
      logic [OUT_W-1:0] cx;
      logic [OUT_W-1:0] cy;
      logic [OUT_W-1:0] cz;
      logic             nw;
   } centroid_type;

   typedef enum logic {ROW_WRITE, ROW_VOXEL} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [REG_IW-1:0] idx;
      logic [CFG_W-1:0]  val;
      logic [VOX_W-1:0]  vox;
      bit                typed;
      centroid_type      want;
   } plan_row_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              push      = 1'b0;
   logic              full;
   logic [VOX_W-1:0]  req_voxel = '0;
   logic              empty;
   logic              pop       = 1'b0;
   logic [OUT_W-1:0]  rsp_center_x;
   logic [OUT_W-1:0]  rsp_center_y;
   logic [OUT_W-1:0]  rsp_center_z;
   logic              rsp_no_weight;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [CSR_AW-1:0] paddr     = '0;
   logic [CSR_DW-1:0] pwdata    = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   // register shadow and volume model state
   logic [CFG_W-1:0]  shadow [5];
   logic [7:0]        at_col, at_row, at_slice;
   logic [W_BITS-1:0] weight_acc;
   logic [M_BITS-1:0] xmom_acc, ymom_acc, zmom_acc;

   centroid_type centroid_q [$];
   plan_row_type plan_rows [$];

   int mismatches     = 0;
   int voxels_sent    = 0;
   int centroids_due  = 0;
   int centroids_seen = 0;
   int no_weight_seen = 0;
   int writes_done    = 0;
   int phases         = 0;
   int idle_cycles    = 0;
   int pop_hold       = 0;
   bit dirty          = 1'b0;
   bit no_idle        = 1'b0;

   volume_weighted_centroid_core #(
      .MAX_X     (MAX_X),
      .MAX_Y     (MAX_Y),
      .MAX_Z     (MAX_Z),
      .FRAC_BITS (FRAC)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_voxel     (req_voxel),
      .empty         (empty),
      .pop           (pop),
      .rsp_center_x  (rsp_center_x),
      .rsp_center_y  (rsp_center_y),
      .rsp_center_z  (rsp_center_z),
      .rsp_no_weight (rsp_no_weight),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always #1 clock = ~clock;

   // effective size: zero acts as one, above the limit acts as the limit
   function automatic int span(input logic [CFG_W-1:0] v, input int lim);
      if (v == 0) return 1;
      if (int'(v) > lim) return lim;
      return int'(v);
   endfunction

   // floor(num * 2^FRAC / den), saturated to the output width
   function automatic logic [OUT_W-1:0] q_frac(input logic [M_BITS-1:0] num,
                                               input logic [W_BITS-1:0] den);
      logic [63:0] q;
      q = ({16'd0, num} << FRAC) / {24'd0, den};
      return (q > 64'hFFFF) ? 16'hFFFF : q[OUT_W-1:0];
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [VOX_W-1:0] pick_voxel(input int style);
      case (style)
         0: return '0;
         1: return 16'hFFFF;
         2: return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'h0000;
         3: return 16'($urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   // one voxel into the model; done marks the end of a volume
   task automatic fold_voxel(input logic [VOX_W-1:0] v, output bit done,
                             output centroid_type c);
      int xs, ys, zs, zone;
      bit end_col, end_row, end_slc;
      xs   = span(shadow[REG_X_SIZE], MAX_X);
      ys   = span(shadow[REG_Y_SIZE], MAX_Y);
      zs   = span(shadow[REG_Z_SIZE], MAX_Z);
      zone = int'(at_slice) + 1;
      if (zone >= int'(shadow[REG_FIRST_SLICE]) &&
          zone <= int'(shadow[REG_LAST_SLICE])) begin
         weight_acc = weight_acc + v;
         xmom_acc   = xmom_acc + v * at_col;
         ymom_acc   = ymom_acc + v * at_row;
         zmom_acc   = zmom_acc + v * at_slice;
      end
      end_col = int'(at_col) + 1 >= xs;
      end_row = int'(at_row) + 1 >= ys;
      end_slc = int'(at_slice) + 1 >= zs;
      done = 1'b0;
      c    = '0;
      if (end_col && end_row && end_slc) begin
         done = 1'b1;
         if (weight_acc == 0) begin
            c.nw = 1'b1;
         end else begin
            c.cx = q_frac(xmom_acc, weight_acc);
            c.cy = q_frac(ymom_acc, weight_acc);
            c.cz = q_frac(zmom_acc, weight_acc);
         end
         at_col     = '0;
         at_row     = '0;
         at_slice   = '0;
         weight_acc = '0;
         xmom_acc   = '0;
         ymom_acc   = '0;
         zmom_acc   = '0;
      end else if (!end_col) begin
         at_col = at_col + 1;
      end else begin
         at_col = '0;
         if (!end_row) begin
            at_row = at_row + 1;
         end else begin
            at_row   = '0;
            at_slice = at_slice + 1;
         end
      end
   endtask

   // voxel beat; push stays high after acceptance unless a gap follows
   task automatic send_voxel(input logic [VOX_W-1:0] v, input bit typed,
                             input centroid_type want);
      int           gap;
      bit           done;
      centroid_type c;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push      <= 1'b1;
      req_voxel <= v;
      do @(posedge clock); while (full);
      dirty = 1'b1;
      voxels_sent++;
      fold_voxel(v, done, c);
      if (done) begin
         centroid_q.push_back(typed ? want : c);
         centroids_due++;
      end
   endtask

   // hold off the sender until every centroid is out, then let the divider drain
   task automatic quiesce();
      push <= 1'b0;
      while (centroid_q.size() != 0) @(posedge clock);
      repeat (DIVIDE_CYCLES) @(posedge clock);
      dirty = 1'b0;
   endtask

   // setup cycle, then access cycle until pready
   task automatic csr_access(input bit wr, input logic [REG_IW-1:0] idx,
                             input logic [CSR_DW-1:0] data,
                             output logic [CSR_DW-1:0] rd);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic write_reg(input logic [REG_IW-1:0] idx, input logic [CFG_W-1:0] val);
      logic [CSR_DW-1:0] data, unused;
      if (dirty) quiesce();
      data = ($urandom_range(0, 1) == 1) ? CSR_DW'($urandom) : '0;
      data[CFG_W-1:0] = val;
      csr_access(1'b1, idx, data, unused);
      shadow[idx] = val;
      writes_done++;
   endtask

   task automatic check_reg(input logic [REG_IW-1:0] idx, input logic [CFG_W-1:0] want);
      logic [CSR_DW-1:0] got;
      csr_access(1'b0, idx, '0, got);
      if (got[CFG_W-1:0] !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("register %0d read back %h, expected %h", idx, got[CFG_W-1:0], want);
      end
   endtask

   task automatic add_row(input row_kind_type kind, input logic [REG_IW-1:0] idx,
                          input logic [CFG_W-1:0] val, input logic [VOX_W-1:0] vox,
                          input bit typed, input centroid_type want);
      plan_row_type r;
      r.kind  = kind;
      r.idx   = idx;
      r.val   = val;
      r.vox   = vox;
      r.typed = typed;
      r.want  = want;
      plan_rows.push_back(r);
   endtask

   // centroid beats: random pop stalls, compare against the oldest expectation
   always @(posedge clock) begin
      centroid_type got, want;
      if (reset) begin
         pop      <= 1'b0;
         pop_hold <= 0;
      end else begin
         if (pop && !empty) begin
            got = {rsp_center_x, rsp_center_y, rsp_center_z, rsp_no_weight};
            centroids_seen++;
            if (got.nw) no_weight_seen++;
            if (centroid_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("centroid beat with nothing expected: x=%h y=%h z=%h nw=%b",
                           got.cx, got.cy, got.cz, got.nw);
            end else begin
               want = centroid_q.pop_front();
               if (got.cx !== want.cx || got.cy !== want.cy ||
                   got.cz !== want.cz || got.nw !== want.nw) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("centroid %0d: want x=%h y=%h z=%h nw=%b, got x=%h y=%h z=%h nw=%b",
                              centroids_seen, want.cx, want.cy, want.cz, want.nw,
                              got.cx, got.cy, got.cz, got.nw);
               end
            end
         end
         if (no_idle) begin
            pop <= 1'b1;
         end else if (pop_hold > 0) begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
         end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 3) == 0) pop_hold <= pick_gap();
         end
      end
   end

   // watchdog: cycles without any beat on any port
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("no beat for %0d cycles, %0d centroids outstanding",
                  WATCHDOG_LIMIT, centroid_q.size());
         $display("[volume_weighted_centroid_core] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int               shape, sel, count, vol, nvol, style, zs, fi;
      logic [CFG_W-1:0] xv, yv, zv, fv, lv;

      shadow[REG_X_SIZE]      = SIZE_RESET;
      shadow[REG_Y_SIZE]      = SIZE_RESET;
      shadow[REG_Z_SIZE]      = SIZE_RESET;
      shadow[REG_FIRST_SLICE] = FIRST_RESET;
      shadow[REG_LAST_SLICE]  = LAST_RESET;
      at_col     = '0;
      at_row     = '0;
      at_slice   = '0;
      weight_acc = '0;
      xmom_acc   = '0;
      ymom_acc   = '0;
      zmom_acc   = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // register values after reset
      check_reg(REG_X_SIZE, SIZE_RESET);
      check_reg(REG_Y_SIZE, SIZE_RESET);
      check_reg(REG_Z_SIZE, SIZE_RESET);
      check_reg(REG_FIRST_SLICE, FIRST_RESET);
      check_reg(REG_LAST_SLICE, LAST_RESET);

      // directed table
      // single voxel volumes: full scale and zero weight
      add_row(ROW_WRITE, REG_X_SIZE,      9'd1,   '0, 0, '0);
      add_row(ROW_WRITE, REG_Y_SIZE,      9'd1,   '0, 0, '0);
      add_row(ROW_WRITE, REG_Z_SIZE,      9'd1,   '0, 0, '0);
      add_row(ROW_WRITE, REG_FIRST_SLICE, 9'd1,   '0, 0, '0);
      add_row(ROW_WRITE, REG_LAST_SLICE,  9'd1,   '0, 0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'hFFFF, 1, {16'h0000, 16'h0000, 16'h0000, 1'b0});
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'h0000, 1, {16'h0000, 16'h0000, 16'h0000, 1'b1});
      // two voxel row, all weight on x = 1
      add_row(ROW_WRITE, REG_X_SIZE,      9'd2,   '0, 0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'h0000, 0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'hFFFF, 1, {16'h0100, 16'h0000, 16'h0000, 1'b0});
      // zero sizes act as one; y centroid 3/4
      add_row(ROW_WRITE, REG_X_SIZE,      9'd0,   '0, 0, '0);
      add_row(ROW_WRITE, REG_Y_SIZE,      9'd2,   '0, 0, '0);
      add_row(ROW_WRITE, REG_Z_SIZE,      9'd0,   '0, 0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'd1,   0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'd3,   1, {16'h0000, 16'h00C0, 16'h0000, 1'b0});
      // window of one slice in the middle
      add_row(ROW_WRITE, REG_Y_SIZE,      9'd1,   '0, 0, '0);
      add_row(ROW_WRITE, REG_Z_SIZE,      9'd3,   '0, 0, '0);
      add_row(ROW_WRITE, REG_FIRST_SLICE, 9'd2,   '0, 0, '0);
      add_row(ROW_WRITE, REG_LAST_SLICE,  9'd2,   '0, 0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'd5,   0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'd7,   0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'd9,   1, {16'h0000, 16'h0000, 16'h0100, 1'b0});
      // inverted window: nothing sums
      add_row(ROW_WRITE, REG_FIRST_SLICE, 9'd3,   '0, 0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'd1,   0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'd1,   0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'd1,   1, {16'h0000, 16'h0000, 16'h0000, 1'b1});
      // first slice zero and last slice all ones: whole volume, z = 8/6
      add_row(ROW_WRITE, REG_FIRST_SLICE, 9'd0,   '0, 0, '0);
      add_row(ROW_WRITE, REG_LAST_SLICE,  9'd511, '0, 0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'd1,   0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'd2,   0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'd3,   1, {16'h0000, 16'h0000, 16'h0155, 1'b0});
      // window beyond the last slice
      add_row(ROW_WRITE, REG_FIRST_SLICE, 9'd4,   '0, 0, '0);
      add_row(ROW_WRITE, REG_LAST_SLICE,  9'd5,   '0, 0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'd1,   0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'd1,   0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'd1,   1, {16'h0000, 16'h0000, 16'h0000, 1'b1});
      // row shrunk under the column counter mid-volume
      add_row(ROW_WRITE, REG_Z_SIZE,      9'd1,   '0, 0, '0);
      add_row(ROW_WRITE, REG_X_SIZE,      9'd3,   '0, 0, '0);
      add_row(ROW_WRITE, REG_FIRST_SLICE, 9'd1,   '0, 0, '0);
      add_row(ROW_WRITE, REG_LAST_SLICE,  9'd1,   '0, 0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'h8000, 0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'h8000, 0, '0);
      add_row(ROW_WRITE, REG_X_SIZE,      9'd2,   '0, 0, '0);
      add_row(ROW_VOXEL, REG_X_SIZE, '0, 16'h8000, 0, '0);

      foreach (plan_rows[i]) begin
         if (plan_rows[i].kind == ROW_WRITE)
            write_reg(plan_rows[i].idx, plan_rows[i].val);
         else
            send_voxel(plan_rows[i].vox, plan_rows[i].typed, plan_rows[i].want);
      end

      // random phases, each with its own register settings
      while (voxels_sent < N_VOXELS) begin
         phases++;
         if (dirty) quiesce();
         no_idle = ($urandom_range(0, 3) == 0);
         shape   = $urandom_range(0, 11);
         case (shape)
            0: begin
               xv = ($urandom_range(0, 1) == 1) ? 9'd256 : 9'($urandom_range(257, 511));
               yv = ($urandom_range(0, 1) == 1) ? 9'd1 : 9'd0;
               zv = 9'd1;
            end
            1: begin
               xv = 9'd1;
               yv = ($urandom_range(0, 1) == 1) ? 9'd256 : 9'($urandom_range(257, 511));
               zv = ($urandom_range(0, 1) == 1) ? 9'd1 : 9'd0;
            end
            2: begin
               xv = ($urandom_range(0, 1) == 1) ? 9'd1 : 9'd0;
               yv = 9'd1;
               zv = ($urandom_range(0, 1) == 1) ? 9'd256 : 9'($urandom_range(257, 511));
            end
            default: begin
               xv = 9'($urandom_range(0, 6));
               yv = 9'($urandom_range(0, 4));
               zv = 9'($urandom_range(0, 4));
            end
         endcase
         zs  = span(zv, MAX_Z);
         sel = $urandom_range(0, 9);
         case (sel)
            0: begin fv = 9'd0;   lv = 9'd511; end
            1: begin fv = 9'd1;   lv = 9'd256; end
            2: begin
               // inverted window
               fi = $urandom_range(2, zs + 1);
               fv = 9'(fi);
               lv = 9'(fi - 1);
            end
            3: begin
               // window past the volume
               fi = $urandom_range(zs + 1, zs + 3);
               fv = 9'(fi);
               lv = 9'($urandom_range(fi, fi + 200));
            end
            4: begin
               fv = 9'($urandom_range(0, 511));
               lv = 9'($urandom_range(0, 511));
            end
            default: begin
               fi = $urandom_range(1, zs);
               fv = 9'(fi);
               lv = 9'($urandom_range(fi, zs));
            end
         endcase
         write_reg(REG_X_SIZE, xv);
         write_reg(REG_Y_SIZE, yv);
         write_reg(REG_Z_SIZE, zv);
         write_reg(REG_FIRST_SLICE, fv);
         write_reg(REG_LAST_SLICE, lv);

         // whole volumes, sometimes followed by a partial one left open
         vol   = span(xv, MAX_X) * span(yv, MAX_Y) * zs;
         nvol  = (vol >= 64) ? 1 : $urandom_range(1, 4);
         count = vol * nvol;
         if (vol > 1 && $urandom_range(0, 3) == 0) count += $urandom_range(1, vol - 1);
         style = $urandom_range(0, 5);
         for (int n = 0; n < count; n++) send_voxel(pick_voxel(style), 1'b0, '0);
      end

      quiesce();
      if (centroid_q.size() != 0) begin
         mismatches++;
         $display("%0d centroids never came out", centroid_q.size());
      end
      for (int i = 0; i < 5; i++) check_reg(REG_IW'(i), shadow[i]);

      $display("covered %0d voxels over the directed table and %0d random phases, %0d writes",
               voxels_sent, phases, writes_done);
      $display("checked %0d centroids (%0d with no weight), %0d mismatches",
               centroids_seen, no_weight_seen, mismatches);
      if (mismatches == 0)
         $display("[volume_weighted_centroid_core] OK");
      else
         $display("[volume_weighted_centroid_core] ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/vwc_pkg.sv
sv/vwc_front.sv
sv/vwc_queue.sv
sv/vwc_back.sv
sv/volume_weighted_centroid_core.sv
dv/tb_volume_weighted_centroid_core.sv
